[hw/rtl/prrq_pkg.sv]
// Shared types and constants for the per-user round-robin queue core.
// Used by prrq_ctrl, prrq_dp and the top module; depends on nothing.
package prrq_pkg;

    localparam int DEF_NUM_USERS   = 16;
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TAG_WIDTH   = 32;

    localparam int OPCODE_W    = 2;
    localparam int USER_ID_W   = 4;
    localparam int CMD_TAG_W   = 32;
    localparam int STATUS_W    = 2;
    localparam int GRANT_TAG_W = 32;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    localparam logic [OPCODE_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DONE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NOP  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE_ERR = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } t_dp_cmd;

endpackage

[hw/rtl/prrq_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module prrq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/prrq_ctrl.sv]
// Controller state machine: input and output handshakes, datapath commands.
// Depends on prrq_pkg.
module prrq_ctrl
    import prrq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   accept;
    logic   emit;

    assign out_free   = !r_out_valid || i_m_tready;
    assign emit       = (r_state == S_RESP) && out_free;
    assign o_s_tready = (r_state == S_IDLE) || emit;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) n_state = accept ? S_EXEC : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        priority if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_cmd.load = accept;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_cmd.emit = emit;

endmodule

[hw/rtl/prrq_dp.sv]
// Datapath: per-user pointers, counts and busy flags, round-robin pick,
// tag RAM and result registers. Depends on prrq_pkg and prrq_ram.
module prrq_dp
    import prrq_pkg::*;
#(
    parameter int NUM_USERS   = DEF_NUM_USERS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TAG_WIDTH   = DEF_TAG_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [OPCODE_W-1:0]  i_opcode,
    input  logic [USER_ID_W-1:0] i_user_id,
    input  logic [CMD_TAG_W-1:0] i_command_tag,
    output logic [M_TDATA_W-1:0] o_tdata,
    output logic [M_TUSER_W-1:0] o_tuser
);

    localparam int UW     = $clog2(NUM_USERS);
    localparam int SW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUMW   = CW + 1;
    localparam int RAM_AW = UW + SW;
    localparam int RAM_D  = NUM_USERS * (1 << SW);
    localparam int PAD_W  = M_TDATA_W - USER_ID_W - GRANT_TAG_W;

    logic [OPCODE_W-1:0]  r_op;
    logic [USER_ID_W-1:0] r_user;
    logic [TAG_WIDTH-1:0] r_tag;
    logic [UW-1:0]        r_win;
    logic                 r_found;

    logic [SW-1:0]        r_head [NUM_USERS];
    logic [CW-1:0]        r_count [NUM_USERS];
    logic [NUM_USERS-1:0] r_busy;
    logic [UW-1:0]        r_last;
    logic                 r_last_valid;

    logic [STATUS_W-1:0]  r_res_status;
    logic                 r_res_granted;
    logic [UW-1:0]        r_res_user;

    logic [STATUS_W-1:0]    r_out_status;
    logic                   r_out_granted;
    logic [USER_ID_W-1:0]   r_out_user;
    logic [GRANT_TAG_W-1:0] r_out_tag;

    logic [NUM_USERS-1:0] eligible, mask, hi, pick, onehot;
    logic [UW-1:0]        win;
    logic                 found;

    logic                 user_ok;
    logic [UW-1:0]        user_idx;
    logic [UW-1:0]        sel;
    logic [SW-1:0]        cur_head;
    logic [CW-1:0]        cur_count;
    logic [SUMW-1:0]      sum;
    logic [SW-1:0]        slot;
    logic [SW-1:0]        head_inc;
    logic                 push_ok, done_ok;
    logic                 is_push, is_pop, is_done;
    logic                 ram_en, ram_we;
    logic [RAM_AW-1:0]    ram_addr;
    logic [TAG_WIDTH-1:0] ram_rdata;

    // Round-robin pick over eligible users, starting after the last grant (from user 0 after reset or an empty pop)
    always_comb begin
        win = '0;
        for (int i = 0; i < NUM_USERS; i++) begin
            eligible[i] = !r_busy[i] && (r_count[i] != '0);
            mask[i]     = r_last_valid && (32'(i) > 32'(r_last));
        end
        hi     = eligible & mask;
        pick   = (|hi) ? hi : eligible;
        onehot = pick & (~pick + 1'b1);
        for (int i = 0; i < NUM_USERS; i++) begin
            if (onehot[i]) win = win | UW'(i);
        end
        found = |eligible;
    end

    assign is_push  = (r_op == OP_PUSH);
    assign is_pop   = (r_op == OP_POP);
    assign is_done  = (r_op == OP_DONE);
    assign user_ok  = (32'(r_user) < NUM_USERS);
    assign user_idx = UW'(r_user);
    assign sel      = is_pop ? r_win : user_idx;

    always_comb begin
        cur_head  = r_head[sel];
        cur_count = r_count[sel];
        sum       = SUMW'(cur_head) + SUMW'(cur_count);
        slot      = (sum >= SUMW'(QUEUE_DEPTH)) ? SW'(sum - SUMW'(QUEUE_DEPTH)) : SW'(sum);
        head_inc  = (cur_head == SW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
        push_ok   = user_ok && (cur_count < CW'(QUEUE_DEPTH));
        done_ok   = user_ok && r_busy[sel] && (cur_count != '0);
    end

    assign ram_we   = i_cmd.exec && is_push && push_ok;
    assign ram_en   = ram_we || (i_cmd.exec && is_pop && r_found);
    assign ram_addr = {sel, (is_push ? slot : cur_head)};

    prrq_ram #(
        .WIDTH (TAG_WIDTH),
        .DEPTH (RAM_D)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_tag),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_user  <= i_user_id;
            r_tag   <= TAG_WIDTH'(i_command_tag);
            r_win   <= win;
            r_found <= found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_USERS; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
            r_busy       <= '0;
            r_last       <= '0;
            r_last_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            if (is_push && push_ok) begin
                r_count[sel] <= cur_count + 1'b1;
            end
            if (is_pop) begin
                if (r_found) begin
                    r_busy[r_win] <= 1'b1;
                    r_last        <= r_win;
                    r_last_valid  <= 1'b1;
                end else begin
                    r_last_valid  <= 1'b0;
                end
            end
            if (is_done && done_ok) begin
                r_head[sel]  <= head_inc;
                r_count[sel] <= cur_count - 1'b1;
                r_busy[sel]  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            unique case (r_op)
                OP_PUSH: begin
                    r_res_status  <= push_ok ? ST_OK : ST_OVERFLOW;
                    r_res_granted <= 1'b0;
                    r_res_user    <= '0;
                end
                OP_POP: begin
                    r_res_status  <= r_found ? ST_OK : ST_EMPTY;
                    r_res_granted <= r_found;
                    r_res_user    <= r_found ? r_win : '0;
                end
                OP_DONE: begin
                    r_res_status  <= done_ok ? ST_OK : ST_DONE_ERR;
                    r_res_granted <= 1'b0;
                    r_res_user    <= '0;
                end
                OP_NOP: begin
                    r_res_status  <= ST_OK;
                    r_res_granted <= 1'b0;
                    r_res_user    <= '0;
                end
                default: begin
                    r_res_status  <= ST_OK;
                    r_res_granted <= 1'b0;
                    r_res_user    <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status  <= r_res_status;
            r_out_granted <= r_res_granted;
            r_out_user    <= USER_ID_W'(r_res_user);
            r_out_tag     <= r_res_granted ? GRANT_TAG_W'(ram_rdata) : '0;
        end
    end

    assign o_tdata = {{PAD_W{1'b0}}, r_out_tag, r_out_user};
    assign o_tuser = {r_out_granted, r_out_status};

endmodule

[hw/rtl/per_user_round_robin_queue_core.sv]
// Per-user round-robin command queue: one FIFO of tags and one busy flag per
// user. The accept cycle also registers the round-robin winner, and the
// next cycle reads and updates that user's head pointer and count and
// accesses the tag RAM (one port, registered read). The output register
// loads in the response state, overlapping the next accept, so the block
// takes a new item before the last result leaves while the output side
// keeps up; a stalled result keeps the item in the response state and holds
// the input not ready. No clearing pass is needed after reset. Depends on
// prrq_pkg, prrq_ctrl, prrq_dp and prrq_ram.
module per_user_round_robin_queue_core
    import prrq_pkg::*;
#(
    parameter int NUM_USERS   = DEF_NUM_USERS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TAG_WIDTH   = DEF_TAG_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // user_id[3:0], command_tag[35:4], zero pad
    input  logic [S_TUSER_W-1:0] i_s_tuser,  // opcode[1:0]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // grant_user[3:0], grant_tag[35:4], zero pad
    output logic [M_TUSER_W-1:0] o_m_tuser   // status[1:0], granted[2]
);

    t_dp_cmd cmd;

    prrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    prrq_dp #(
        .NUM_USERS   (NUM_USERS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_s_tuser[OPCODE_W-1:0]),
        .i_user_id     (i_s_tdata[USER_ID_W-1:0]),
        .i_command_tag (i_s_tdata[USER_ID_W+CMD_TAG_W-1:USER_ID_W]),
        .o_tdata       (o_m_tdata),
        .o_tuser       (o_m_tuser)
    );

    a_no_accept_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> !cmd.load)
        else $error("item accepted during execute");

    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> cmd.exec)
        else $error("accepted item not executed");

    a_ready_only_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> (cmd.emit || !o_s_tready))
        else $error("ready while result pending");

    a_grant_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[STATUS_W]) |-> (o_m_tuser[STATUS_W-1:0] == ST_OK))
        else $error("grant with non-ok status");

endmodule
